### hdl/dpr_pkg.sv
// Package: payload types, fixed-point constants and CORDIC arctangent table
package dpr_pkg;

	localparam int MAX_STEPS_DEF = 64;
	localparam int CORDIC_ITER_DEF = 16;
	localparam int CD_TABLE_LEN = 24;

	// angles Q3.13: pi and 2*pi
	localparam logic signed [17:0] ANG_PI = 18'sd25736;
	localparam logic signed [17:0] ANG_TWO_PI = 18'sd51472;

	// CORDIC domain, 2^30 units per radian
	localparam int CW = 36;
	localparam logic signed [CW-1:0] CD_PI = 36'sd3373259426;
	localparam logic signed [CW-1:0] CD_HALF_PI = 36'sd1686629713;
	localparam logic signed [CW-1:0] CD_TWO_PI = 36'sd6746518852;
	localparam logic signed [CW-1:0] CD_GAIN = 36'sd652032874;

	typedef struct packed {
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [15:0] start_heading;
		logic [19:0] step_dist;
		logic signed [15:0] turn_step;
		logic rotate_only;
		logic [6:0] step_count;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_heading;
		logic last_sample;
	} pose_t;

	// arctangent of 2^-i, 2^30 units per radian, truncated
	function automatic logic signed [CW-1:0] atan_entry(input logic [4:0] i);
		logic signed [CW-1:0] r;
		unique case (i)
			5'd0: r = 36'sd843314856;
			5'd1: r = 36'sd497837829;
			5'd2: r = 36'sd263043836;
			5'd3: r = 36'sd133525158;
			5'd4: r = 36'sd67021686;
			5'd5: r = 36'sd33543515;
			5'd6: r = 36'sd16775850;
			5'd7: r = 36'sd8388437;
			5'd8: r = 36'sd4194282;
			5'd9: r = 36'sd2097149;
			5'd10: r = 36'sd1048575;
			5'd11: r = 36'sd524287;
			5'd12: r = 36'sd262143;
			5'd13: r = 36'sd131071;
			5'd14: r = 36'sd65535;
			5'd15: r = 36'sd32767;
			5'd16: r = 36'sd16383;
			5'd17: r = 36'sd8191;
			5'd18: r = 36'sd4095;
			5'd19: r = 36'sd2047;
			5'd20: r = 36'sd1023;
			5'd21: r = 36'sd511;
			5'd22: r = 36'sd255;
			5'd23: r = 36'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ROT,
		ST_MUL,
		ST_UPD,
		ST_EMIT
	} be_state_t;

endpackage

### hdl/dpr_front.sv
// Front end: accepts requests, clamps step count, writes them into a two-entry queue
module dpr_front import dpr_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input req_t req,
	output logic q_valid,
	input logic q_take,
	output req_t q_req
);

	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	req_t mem_q [2];
	req_t clamped;
	logic do_push;

	// clamp step count to the maximum
	always_comb begin
		clamped = req;
		if (req.step_count > 7'(MAX_STEPS))
			clamped.step_count = 7'(MAX_STEPS);
	end

	assign full = cnt_q[1];
	assign do_push = push && !full;
	assign q_valid = cnt_q != 2'd0;
	assign q_req = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= clamped;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (q_take && q_valid) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(q_take && q_valid);
		end
	end

endmodule

### hdl/dpr_back.sv
// Back end: per-step midpoint integration with iterative CORDIC and output register
module dpr_back import dpr_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_take,
	input req_t q_req,
	output logic empty,
	input logic pop,
	output pose_t pose
);

	localparam int NIT = (CORDIC_ITERATIONS < CD_TABLE_LEN) ? CORDIC_ITERATIONS : CD_TABLE_LEN;

	be_state_t st_q, st_d;
	logic signed [31:0] cx_q, cy_q;
	logic signed [15:0] ch_q, ang_q;
	logic [19:0] lin_q;
	logic rot_q;
	logic [6:0] left_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic neg_q;
	logic [4:0] it_q;
	logic signed [56:0] px_q, py_q;
	logic out_v_q;
	pose_t out_q;

	logic signed [17:0] mid2;
	logic signed [CW-1:0] a0, a1;
	logic signed [CW-1:0] dx, dy;
	logic signed [CW-1:0] cc, ss;
	logic signed [33:0] nx, ny;
	logic signed [17:0] hsum, hw;
	logic signed [56:0] rx, ry;

	assign empty = !out_v_q;
	assign pose = out_q;

	// midpoint angle, wrap and fold into CORDIC range
	always_comb begin
		mid2 = 18'(ch_q) * 18'sd2 + 18'(ang_q);
		a0 = CW'(mid2) <<< 16;
		if (a0 > CD_PI) a0 = a0 - CD_TWO_PI;
		else if (a0 <= -CD_PI) a0 = a0 + CD_TWO_PI;
		a1 = a0;
		if (a0 > CD_HALF_PI) a1 = a0 - CD_PI;
		else if (a0 < -CD_HALF_PI) a1 = a0 + CD_PI;
	end

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign cc = neg_q ? -x_q : x_q;
	assign ss = neg_q ? -y_q : y_q;

	// rounding, position sums and heading wrap; saturation is applied in ST_UPD
	always_comb begin
		rx = (px_q + 57'sd536870912) >>> 30;
		ry = (py_q + 57'sd536870912) >>> 30;
		nx = 34'(cx_q) + (rot_q ? 34'sd0 : 34'(rx));
		ny = 34'(cy_q) + (rot_q ? 34'sd0 : 34'(ry));
		hsum = 18'(ch_q) + 18'(ang_q);
		hw = hsum;
		if (hsum > ANG_PI) hw = hsum - ANG_TWO_PI;
		else if (hsum <= -ANG_PI) hw = hsum + ANG_TWO_PI;
	end

	// sequencer next state
	always_comb begin
		st_d = st_q;
		q_take = 1'b0;
		unique case (st_q)
			ST_IDLE: if (q_valid) begin
				q_take = 1'b1;
				st_d = ST_PREP;
			end
			ST_PREP: begin
				if (left_q == 7'd0) st_d = ST_IDLE;
				else if (rot_q) st_d = ST_UPD;
				else st_d = ST_ROT;
			end
			ST_ROT: if (it_q == 5'(NIT - 1)) st_d = ST_MUL;
			ST_MUL: st_d = ST_UPD;
			ST_UPD: st_d = ST_EMIT;
			ST_EMIT: if (!out_v_q || pop) st_d = ST_PREP;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// output valid: set on a new sample, cleared on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (st_q == ST_EMIT && (!out_v_q || pop)) out_v_q <= 1'b1;
		else if (pop && out_v_q) out_v_q <= 1'b0;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; ch_q <= '0; ang_q <= '0;
			lin_q <= '0; rot_q <= 1'b0; left_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (q_valid) begin
					cx_q <= q_req.start_x;
					cy_q <= q_req.start_y;
					ch_q <= q_req.start_heading;
					ang_q <= q_req.turn_step;
					lin_q <= q_req.step_dist;
					rot_q <= q_req.rotate_only;
					left_q <= q_req.step_count;
				end
				ST_UPD: begin
					cx_q <= (nx > 34'sd2147483647) ? 32'sh7fffffff :
						(nx < -34'sd2147483648) ? 32'sh80000000 : nx[31:0];
					cy_q <= (ny > 34'sd2147483647) ? 32'sh7fffffff :
						(ny < -34'sd2147483648) ? 32'sh80000000 : ny[31:0];
					ch_q <= hw[15:0];
					left_q <= left_q - 7'd1;
				end
				default: ;
			endcase
		end
	end

	// CORDIC iterations, products and output payload
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_PREP: begin
				x_q <= CD_GAIN;
				y_q <= '0;
				z_q <= a1;
				neg_q <= (a0 > CD_HALF_PI) || (a0 < -CD_HALF_PI);
				it_q <= '0;
			end
			ST_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - atan_entry(it_q);
				end else begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + atan_entry(it_q);
				end
				it_q <= it_q + 5'd1;
			end
			ST_MUL: begin
				px_q <= 57'(cc) * 57'(signed'({1'b0, lin_q}));
				py_q <= 57'(ss) * 57'(signed'({1'b0, lin_q}));
			end
			ST_EMIT: if (!out_v_q || pop) begin
				out_q.pose_x <= cx_q;
				out_q.pose_y <= cy_q;
				out_q.pose_heading <= ch_q;
				out_q.last_sample <= left_q == 7'd0;
			end
			default: ;
		endcase
	end

endmodule

### hdl/differential_pose_rollout.sv
// Top level: differential-drive pose rollout, front queue plus stepping back end
//
//  channel | handshake   | payload
//  request | push / full | req  (req_t)
//  sample  | pop / empty | pose (pose_t)
//
// Each step runs PREP, then (when moving) the shared iterative CORDIC in ROT and the
// products in MUL, then UPD and EMIT; a rotation-only step skips ROT and MUL.
// Reset clears control state and the working pose, not the output payload; no clearing pass.
// Results hold in one output register; a stalled pop holds the back end once its
// next sample is ready, while the front takes up to two more requests.
module differential_pose_rollout import dpr_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input req_t req,
	output logic empty,
	input logic pop,
	output pose_t pose
);

	logic q_valid, q_take;
	req_t q_req;

	dpr_front #(.MAX_STEPS(MAX_STEPS)) u_front (
		.clk, .arst_n, .push, .full, .req,
		.q_valid, .q_take, .q_req
	);

	dpr_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_req,
		.empty, .pop, .pose
	);

endmodule

### verif/differential_pose_rollout_test.sv
// Testbench for the differential pose rollout block: directed and random rollout checks
module differential_pose_rollout_test import dpr_pkg::*; ();

	localparam int ITERS = CORDIC_ITER_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	req_t req = '0;
	logic full, empty;
	pose_t pose;

	pose_t expected_poses[$];
	int mismatches = 0;
	int pop_mode = 0;
	int pop_hold = 0;

	differential_pose_rollout u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .pose(pose)
	);

	always #4 clk = ~clk;

	// arctangent table, 2^30 units per radian
	function automatic longint atan_of(int i);
		longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
			262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
			255, 127};
		return t[i];
	endfunction

	// iterative sine and cosine with range fold
	function automatic void rotate_unit(input longint ang, output longint c,
			output longint s);
		longint x, y, z, dx, dy;
		bit neg;
		x = 652032874;
		y = 0;
		neg = 0;
		if (ang > 64'sd3373259426) ang -= 64'sd6746518852;
		else if (ang <= -64'sd3373259426) ang += 64'sd6746518852;
		if (ang > 64'sd1686629713) begin
			ang -= 64'sd3373259426;
			neg = 1;
		end else if (ang < -64'sd1686629713) begin
			ang += 64'sd3373259426;
			neg = 1;
		end
		z = ang;
		for (int i = 0; i < ITERS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_of(i);
			end else begin
				x += dx;
				y -= dy;
				z += atan_of(i);
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic int clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	// expand one request into its pose samples
	task automatic predict_rollout(req_t r);
		int px, py, hd, n;
		longint c, s, mid;
		pose_t p;
		px = r.start_x;
		py = r.start_y;
		hd = r.start_heading;
		n = (r.step_count > MAX_STEPS_DEF) ? MAX_STEPS_DEF : r.step_count;
		while (n > 0) begin
			if (!r.rotate_only) begin
				mid = 2 * longint'(hd) + longint'(r.turn_step);
				rotate_unit(mid * 65536, c, s);
				px = clamp32(longint'(px) +
					((longint'(r.step_dist) * c + (64'sd1 << 29)) >>> 30));
				py = clamp32(longint'(py) +
					((longint'(r.step_dist) * s + (64'sd1 << 29)) >>> 30));
			end
			hd = hd + r.turn_step;
			if (hd > 25736) hd -= 51472;
			else if (hd <= -25736) hd += 51472;
			n--;
			p.pose_x = px;
			p.pose_y = py;
			p.pose_heading = hd[15:0];
			p.last_sample = (n == 0);
			expected_poses = {expected_poses, p};
		end
	endtask

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	// send one request, with an optional random gap before it; called at a falling edge
	task automatic send_request(req_t r, bit gaps = 1);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(negedge clk);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_rollout(r);
		@(negedge clk);
	endtask

	// drain side: pop held high in mode 0, else random pop stalls, mostly short, a few long
	always @(negedge clk) begin
		if (pop_mode == 0) pop <= 1'b1;
		else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if ($urandom_range(0, 3) == 0) begin
			pop <= 1'b0;
			pop_hold = gap_len();
		end else pop <= 1'b1;
	end

	// check every sample transfer against the oldest prediction
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && pop && !empty) begin
			if (expected_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected sample %p", pose);
			end else begin
				e = expected_poses.pop_front();
				if (pose.pose_x !== e.pose_x || pose.pose_y !== e.pose_y ||
						pose.pose_heading !== e.pose_heading ||
						pose.last_sample !== e.last_sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample mismatch: expected %p actual %p", e, pose);
				end
			end
		end
	end

	function automatic req_t random_request(int max_steps);
		req_t r;
		r.start_x = $urandom;
		r.start_y = $urandom;
		r.start_heading = 16'($urandom_range(0, 51471) - 25735);
		r.step_dist = ($urandom_range(0, 3) == 0) ? 20'hfffff : 20'($urandom);
		r.turn_step = 16'($urandom_range(0, 51472) - 25736);
		r.rotate_only = ($urandom_range(0, 4) == 0);
		r.step_count = 7'($urandom_range(0, max_steps));
		return r;
	endfunction

	// extremes, zero count, over-limit count, saturation, rotation
	task automatic test_directed();
		req_t r;
		r = '{32'sh7fffff00, 32'sh80000100, 16'sd0, 20'hfffff, 16'sd0, 1'b0, 7'd3};
		send_request(r, 0);
		r = '{32'sh80000000, 32'sh7fffffff, 16'sd25736, 20'hfffff, 16'sd25736, 1'b0, 7'd4};
		send_request(r, 0);
		r = '{32'sd0, 32'sd0, -16'sd25735, 20'd65536, -16'sd25736, 1'b0, 7'd5};
		send_request(r, 0);
		r = '{32'sd5, 32'sd7, 16'sd100, 20'd0, 16'sd0, 1'b0, 7'd0};
		send_request(r, 0);
		r = '{32'sd5, 32'sd7, 16'sd25000, 20'd1000, 16'sd25736, 1'b1, 7'd6};
		send_request(r, 0);
		r = '{32'sd1, 32'sd2, 16'sh7fff, 20'd4096, 16'sd1200, 1'b0, 7'd2};
		send_request(r, 0);
		r = '{32'sd1, 32'sd2, 16'sh8000, 20'd4096, -16'sd1200, 1'b0, 7'd2};
		send_request(r, 0);
		r = '{32'sd0, 32'sd0, 16'sd12868, 20'd70000, 16'sd300, 1'b0, 7'd127};
		send_request(r, 0);
		r = '{32'sd0, 32'sd0, 16'sd0, 20'd70000, 16'sd300, 1'b1, 7'd64};
		send_request(r, 0);
		r = '{-32'sd1, -32'sd1, -16'sd1, 20'h55555, 16'sh5555, 1'b0, 7'h2a};
		send_request(r, 0);
	endtask

	// random requests, mostly short rollouts
	task automatic test_random();
		pop_mode = 1;
		for (int i = 0; i < 420; i++)
			send_request(random_request(($urandom_range(0, 19) == 0) ? 127 : 6));
		pop_mode = 0;
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		push <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0 && expected_poses.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#100000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
hdl/dpr_pkg.sv
hdl/dpr_front.sv
hdl/dpr_back.sv
hdl/differential_pose_rollout.sv
verif/differential_pose_rollout_test.sv
